[rtl/rps_pkg.sv]
package rps_pkg;

    // fixed point of the temperature fields
    localparam int TEMP_FRACTION_BITS = 4;

    localparam int NUM_PHASES = 5;
    localparam int TIME_W     = 19;
    localparam int TEMP_W     = 16;
    localparam int DUR_W      = 16;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int PHASE_W    = 3;
    localparam int PROD_W     = DUR_W + TEMP_W;

    // divider: quotient bits resolved per pipeline stage
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = TEMP_W / DIV_BITS;

    // register reset values
    localparam logic [TEMP_W-1:0] RST_START_TEMP = TEMP_W'(25 << TEMP_FRACTION_BITS);
    localparam logic [CFG_W-1:0]  RST_PREHEAT =
        {TEMP_W'(150 << TEMP_FRACTION_BITS), DUR_W'(90)};
    localparam logic [CFG_W-1:0]  RST_SOAK =
        {TEMP_W'(215 << TEMP_FRACTION_BITS), DUR_W'(80)};
    localparam logic [CFG_W-1:0]  RST_RAMP =
        {TEMP_W'(250 << TEMP_FRACTION_BITS), DUR_W'(30)};
    localparam logic [CFG_W-1:0]  RST_HOLD =
        {TEMP_W'(250 << TEMP_FRACTION_BITS), DUR_W'(30)};
    localparam logic [CFG_W-1:0]  RST_COOL =
        {TEMP_W'(50 << TEMP_FRACTION_BITS), DUR_W'(180)};
    localparam logic [NUM_PHASES-1:0][CFG_W-1:0] RST_PHASE =
        {RST_COOL, RST_HOLD, RST_RAMP, RST_SOAK, RST_PREHEAT};

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_TEMP,
        CFG_PREHEAT,
        CFG_SOAK,
        CFG_RAMP,
        CFG_HOLD,
        CFG_COOL
    } t_cfg_idx;

    // phase codes
    typedef enum logic [PHASE_W-1:0] {
        PH_PREHEAT,
        PH_SOAK,
        PH_RAMP,
        PH_HOLD,
        PH_COOL,
        PH_FINISHED
    } t_phase;

    // profile settings and per-phase values derived from them
    typedef struct packed {
        logic [NUM_PHASES-1:0][TIME_W-1:0] cum;
        logic [NUM_PHASES-1:0][DUR_W-1:0]  dur;
        logic [NUM_PHASES-1:0][TEMP_W-1:0] tgt;
        logic [NUM_PHASES-1:0][TEMP_W-1:0] base;
        logic [NUM_PHASES-1:0][TEMP_W-1:0] mag;
    } t_rps_cfg;

    // transaction after phase selection
    typedef struct packed {
        t_phase            phase;
        logic [TEMP_W-1:0] base;
        logic [TEMP_W-1:0] mag;
        logic [DUR_W-1:0]  into;
        logic [DUR_W-1:0]  dur;
    } t_rps_sel;

    // transaction inside the divider
    typedef struct packed {
        t_phase            phase;
        logic [TEMP_W-1:0] base;
        logic [DUR_W-1:0]  dur;
        logic [DUR_W-1:0]  rem;
        logic [TEMP_W-1:0] lo;
        logic [TEMP_W-1:0] quo;
    } t_rps_div;

endpackage

[rtl/reflow_profile_setpoint_unit.sv]
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_elapsed_seconds[18:0]
// output    out        o_valid / i_ready    o_setpoint[15:0], o_phase[2:0]
// config    in         i_cfg_we             i_cfg_idx[2:0], i_cfg_data[31:0]
//
// one transaction per cycle unless i_ready stalls the output; o_valid rises once the
// transaction has passed 13 register stages: 3 phase-select, 1 multiply, 8 divider
// stages at 2 quotient bits each, 1 output.
// synchronous active-low reset restores the default profile and empties the pipe.
// a stall holds only full stages: empty stages keep loading, so bubbles squeeze out.
module reflow_profile_setpoint_unit
    import rps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [TIME_W-1:0]    i_elapsed_seconds,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [TEMP_W-1:0]    o_setpoint,
    output logic [PHASE_W-1:0]   o_phase
);

    t_rps_cfg          w_cfg;
    logic              w_sel_vld;
    logic              w_sel_rdy;
    t_rps_sel          w_sel;
    logic              w_div_vld;
    logic              w_div_rdy;
    t_rps_div          w_div;
    logic              r_out_vld;
    logic [TEMP_W-1:0] r_setpoint;
    t_phase            r_phase;
    logic [TEMP_W-1:0] n_setpoint;

    rps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    rps_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_time  (i_elapsed_seconds),
        .o_valid (w_sel_vld),
        .i_ready (w_sel_rdy),
        .o_sel   (w_sel)
    );

    rps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sel_vld),
        .o_ready (w_sel_rdy),
        .i_sel   (w_sel),
        .o_valid (w_div_vld),
        .i_ready (w_div_rdy),
        .o_div   (w_div)
    );

    // apply the ramp offset, downward while cooling
    assign w_div_rdy  = !r_out_vld || i_ready;
    assign n_setpoint = (w_div.phase == PH_COOL) ? w_div.base - w_div.quo
                                                 : w_div.base + w_div.quo;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_div_rdy) begin
            r_out_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_rdy) begin
            r_setpoint <= n_setpoint;
            r_phase    <= w_div.phase;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_setpoint = r_setpoint;
    assign o_phase    = r_phase;

`ifndef SYNTHESIS
    // rising phases never overshoot their target
    a_rise_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_phase == PH_PREHEAT || r_phase == PH_SOAK ||
                      r_phase == PH_RAMP || r_phase == PH_HOLD)
        |-> r_setpoint <= w_cfg.tgt[r_phase])
        else $error("rising setpoint above phase target");

    // cooling never undershoots its target
    a_cool_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_phase == PH_COOL |-> r_setpoint >= w_cfg.tgt[NUM_PHASES-1])
        else $error("cooling setpoint below target");

    // finished profile holds the cooling target
    a_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_phase == PH_FINISHED |-> r_setpoint == w_cfg.tgt[NUM_PHASES-1])
        else $error("finished setpoint differs from cooling target");
`endif

endmodule

[rtl/rps_cfg.sv]
module rps_cfg
    import rps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_rps_cfg             o_cfg
);

    logic [TEMP_W-1:0]                 r_start_temp;
    logic [NUM_PHASES-1:0][CFG_W-1:0]  r_phase_cfg;
    logic [NUM_PHASES-1:0][TIME_W-1:0] r_cum;
    logic [NUM_PHASES-1:0][TEMP_W-1:0] r_base;
    logic [NUM_PHASES-1:0][TEMP_W-1:0] r_mag;
    logic [NUM_PHASES-1:0][TIME_W-1:0] n_cum;
    logic [NUM_PHASES-1:0][TEMP_W-1:0] n_base;
    logic [NUM_PHASES-1:0][TEMP_W-1:0] n_mag;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_temp <= RST_START_TEMP;
            r_phase_cfg  <= RST_PHASE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START_TEMP: r_start_temp   <= i_cfg_data[TEMP_W-1:0];
                CFG_PREHEAT:    r_phase_cfg[0] <= i_cfg_data;
                CFG_SOAK:       r_phase_cfg[1] <= i_cfg_data;
                CFG_RAMP:       r_phase_cfg[2] <= i_cfg_data;
                CFG_HOLD:       r_phase_cfg[3] <= i_cfg_data;
                CFG_COOL:       r_phase_cfg[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // phase boundaries and ramp start/size per phase
    always_comb begin
        logic [TIME_W-1:0] sum;
        logic [TEMP_W-1:0] prev;
        logic [TEMP_W-1:0] tgt;
        sum  = '0;
        prev = r_start_temp;
        for (int k = 0; k < NUM_PHASES; k++) begin
            tgt      = r_phase_cfg[k][CFG_W-1:DUR_W];
            sum      = sum + TIME_W'(r_phase_cfg[k][DUR_W-1:0]);
            n_cum[k] = sum;
            if (k != NUM_PHASES - 1) begin
                // rising phase, falling target clamps to target
                if (tgt >= prev) begin
                    n_base[k] = prev;
                    n_mag[k]  = tgt - prev;
                end else begin
                    n_base[k] = tgt;
                    n_mag[k]  = '0;
                end
            end else begin
                // cooling phase, rising target clamps to target
                if (tgt <= prev) begin
                    n_base[k] = prev;
                    n_mag[k]  = prev - tgt;
                end else begin
                    n_base[k] = tgt;
                    n_mag[k]  = '0;
                end
            end
            prev = tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cum  <= n_cum;
        r_base <= n_base;
        r_mag  <= n_mag;
    end

    always_comb begin
        for (int k = 0; k < NUM_PHASES; k++) begin
            o_cfg.dur[k] = r_phase_cfg[k][DUR_W-1:0];
            o_cfg.tgt[k] = r_phase_cfg[k][CFG_W-1:DUR_W];
        end
        o_cfg.cum  = r_cum;
        o_cfg.base = r_base;
        o_cfg.mag  = r_mag;
    end

endmodule

[rtl/rps_phase.sv]
module rps_phase
    import rps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rps_cfg          i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [TIME_W-1:0] i_time,
    output logic              o_valid,
    input  logic              i_ready,
    output t_rps_sel          o_sel
);

    logic                             r_a_vld;
    logic [TIME_W-1:0]                r_a_time;
    logic                             r_b_vld;
    logic [NUM_PHASES-1:0]            r_b_hit;
    logic [NUM_PHASES-1:0][DUR_W-1:0] r_b_into;
    logic                             r_c_vld;
    t_rps_sel                         r_c;
    logic [NUM_PHASES-1:0]            n_b_hit;
    logic [NUM_PHASES-1:0][DUR_W-1:0] n_b_into;
    t_rps_sel                         n_c;
    logic                             w_ld_a;
    logic                             w_ld_b;
    logic                             w_ld_c;

    // per-stage load, bubbles drain forward
    assign w_ld_c  = !r_c_vld || i_ready;
    assign w_ld_b  = !r_b_vld || w_ld_c;
    assign w_ld_a  = !r_a_vld || w_ld_b;
    assign o_ready = w_ld_a;

    // compare against every boundary, offset into every phase
    always_comb begin
        logic [TIME_W-1:0] begin_t;
        logic [TIME_W-1:0] diff;
        begin_t = '0;
        for (int k = 0; k < NUM_PHASES; k++) begin
            n_b_hit[k]  = r_a_time < i_cfg.cum[k];
            diff        = r_a_time - begin_t;
            n_b_into[k] = diff[DUR_W-1:0];
            begin_t     = i_cfg.cum[k];
        end
    end

    // first phase whose end lies beyond the time wins
    always_comb begin
        n_c.phase = PH_FINISHED;
        n_c.base  = i_cfg.tgt[NUM_PHASES-1];
        n_c.mag   = '0;
        n_c.into  = '0;
        n_c.dur   = DUR_W'(1);
        for (int k = NUM_PHASES - 1; k >= 0; k--) begin
            if (r_b_hit[k]) begin
                n_c.phase = t_phase'(PHASE_W'(k));
                n_c.base  = i_cfg.base[k];
                n_c.mag   = i_cfg.mag[k];
                n_c.into  = r_b_into[k];
                n_c.dur   = i_cfg.dur[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            if (w_ld_a) r_a_vld <= i_valid;
            if (w_ld_b) r_b_vld <= r_a_vld;
            if (w_ld_c) r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_a) r_a_time <= i_time;
        if (w_ld_b) begin
            r_b_hit  <= n_b_hit;
            r_b_into <= n_b_into;
        end
        if (w_ld_c) r_c <= n_c;
    end

    assign o_valid = r_c_vld;
    assign o_sel   = r_c;

endmodule

[rtl/rps_div.sv]
module rps_div
    import rps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_rps_sel i_sel,
    output logic     o_valid,
    input  logic     i_ready,
    output t_rps_div o_div
);

    localparam int NST = DIV_STAGES + 1;

    logic [NST-1:0]    r_vld;
    t_rps_div          r_st [NST];
    t_rps_div          n_st [NST];
    logic [NST-1:0]    w_ld;
    logic [PROD_W-1:0] w_prod;

    // one restoring division step
    function automatic t_rps_div div_step(input t_rps_div s);
        t_rps_div       nxt;
        logic [DUR_W:0] sh;
        logic           ge;
        nxt     = s;
        sh      = {s.rem, s.lo[TEMP_W-1]};
        ge      = sh >= {1'b0, s.dur};
        nxt.rem = ge ? DUR_W'(sh - {1'b0, s.dur}) : sh[DUR_W-1:0];
        nxt.lo  = {s.lo[TEMP_W-2:0], 1'b0};
        nxt.quo = {s.quo[TEMP_W-2:0], ge};
        return nxt;
    endfunction

    // load chain from the output side back
    always_comb begin
        w_ld[NST-1] = !r_vld[NST-1] || i_ready;
        for (int s = NST - 2; s >= 0; s--) begin
            w_ld[s] = !r_vld[s] || w_ld[s+1];
        end
    end

    assign o_ready = w_ld[0];

    // offset times ramp size, then quotient bits per stage
    assign w_prod = {{TEMP_W{1'b0}}, i_sel.into} * {{DUR_W{1'b0}}, i_sel.mag};

    always_comb begin
        t_rps_div tmp;
        n_st[0].phase = i_sel.phase;
        n_st[0].base  = i_sel.base;
        n_st[0].dur   = i_sel.dur;
        n_st[0].rem   = w_prod[PROD_W-1:TEMP_W];
        n_st[0].lo    = w_prod[TEMP_W-1:0];
        n_st[0].quo   = '0;
        for (int s = 1; s < NST; s++) begin
            tmp = r_st[s-1];
            for (int b = 0; b < DIV_BITS; b++) begin
                tmp = div_step(tmp);
            end
            n_st[s] = tmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[0]) r_vld[0] <= i_valid;
            for (int s = 1; s < NST; s++) begin
                if (w_ld[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NST; s++) begin
            if (w_ld[s]) r_st[s] <= n_st[s];
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_div   = r_st[NST-1];

endmodule
